/* hw/rtl/srht_pkg.sv */
// Shared constants and types for the sparse range hole tracker.
`default_nettype none
package srht_pkg;
   localparam int MaxHoles    = 64;
   localparam int MaxRegions  = 64;
   localparam int PosBits     = 32;
   localparam int HoleIdxBits = $clog2(MaxHoles);
   localparam int RegIdxBits  = $clog2(MaxRegions);
   localparam int HoleCntBits = $clog2(MaxHoles + 1);
   localparam int RegCntBits  = $clog2(MaxRegions + 1);

   typedef logic [PosBits-1:0] pos_type;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_FIND_REGION = 2'd1,
      OP_FIND_HOLE = 2'd2,
      OP_FILL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL = 2'd2,
      ST_BAD = 2'd3
   } status_type;

   // Entry of either table: start and length.
   typedef struct packed {
      pos_type start;
      pos_type length;
   } entry_type;
endpackage
`default_nettype wire

/* hw/rtl/srht_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module srht_ram #(
   parameter int Depth = 64,
   parameter int Width = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output      logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hw/rtl/sparse_range_hole_tracker_unit.sv */
// Top level of the sparse range hole tracker: sequencer over two table RAMs.
//
//   channel | direction | ports                               | handshake
//   req     | in        | op, position, fill_length           | req_valid/req_ready
//   rsp     | out       | status, item_valid/start/length     | rsp_valid/rsp_ready
//   csr     | in        | total_size                          | csr_write_enable
//
// One word is processed at a time. A clear answers in the cycle after it is taken;
// a lookup reads one entry at a time through the table's RAM read port, checking
// each entry once its read data returns; a split or fill moves sorted entries one
// at a time (read, then write back), as a fill walks the run of holes, inserts its
// region and deletes the consumed holes. Reset clears the counts, the total size
// and the output valid; table contents are undefined until written. A stalled
// result is held in the output register and the next word is taken once it leaves.
`default_nettype none
module sparse_range_hole_tracker_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [1:0]             req_op,
   input  wire srht_pkg::pos_type      req_position,
   input  wire srht_pkg::pos_type      req_fill_length,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [1:0]             rsp_status,
   output      logic                   rsp_item_valid,
   output      srht_pkg::pos_type      rsp_item_start,
   output      srht_pkg::pos_type      rsp_item_length,
   input  wire logic                   csr_write_enable,
   input  wire srht_pkg::pos_type      csr_write_data
);
   import srht_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE    = 13'b0000000000001,
      S_HSCAN   = 13'b0000000000010, // scan holes, one read at a time
      S_HCHECK  = 13'b0000000000100,
      S_SPLIT   = 13'b0000000001000, // shift holes up, top down
      S_RSCAN   = 13'b0000000010000, // scan regions
      S_RCHECK  = 13'b0000000100000,
      S_RUN     = 13'b0000001000000, // walk contiguous holes for a fill
      S_RUNCHK  = 13'b0000010000000,
      S_RINS    = 13'b0000100000000, // shift regions up, insert
      S_HDEL    = 13'b0001000000000, // shift holes down by k
      S_HDELW   = 13'b0010000000000,
      S_RESULT  = 13'b0100000000000, // read result hole
      S_RESW    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [HoleCntBits-1:0] hcnt_ff, hcnt_in;
   logic [RegCntBits-1:0]  rcnt_ff, rcnt_in;
   pos_type total_ff;
   op_type  op_ff, op_in;
   pos_type pos_ff, pos_in, flen_ff, flen_in;
   logic [HoleCntBits-1:0] idx_ff, idx_in;   // hole index i
   logic [HoleCntBits-1:0] k_ff, k_in;       // consumed holes / cursor
   logic [RegCntBits-1:0]  ridx_ff, ridx_in; // region cursor
   pos_type rem_ff, rem_in, cur_ff, cur_in;
   logic partial_ff, partial_in;
   logic pend_ff, pend_in; // a read was issued last cycle

   logic out_v_ff, out_v_in;
   status_type out_st_ff, out_st_in;
   logic out_iv_ff, out_iv_in;
   pos_type out_s_ff, out_s_in, out_l_ff, out_l_in;

   // hole RAM
   logic hwe;
   logic [HoleIdxBits-1:0] hwa, hra;
   entry_type hwd, hrd;
   // region RAM
   logic rwe;
   logic [RegIdxBits-1:0] rwa, rra;
   entry_type rwd, rrd;

   srht_ram #(.Depth(MaxHoles), .Width(2*PosBits)) u_holes (
      .clock(clock), .wr_en(hwe), .wr_addr(hwa), .wr_data(hwd),
      .rd_addr(hra), .rd_data(hrd));
   srht_ram #(.Depth(MaxRegions), .Width(2*PosBits)) u_regions (
      .clock(clock), .wr_en(rwe), .wr_addr(rwa), .wr_data(rwd),
      .rd_addr(rra), .rd_data(rrd));

   assign req_ready       = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_valid       = out_v_ff;
   assign rsp_status      = out_st_ff;
   assign rsp_item_valid  = out_iv_ff;
   assign rsp_item_start  = out_s_ff;
   assign rsp_item_length = out_l_ff;

   logic hin;  // position within read hole (start inclusive, end exclusive)
   assign hin = (hrd.start <= pos_ff) && ((pos_ff - hrd.start) < hrd.length);

   always_comb begin
      state_in = state_ff;
      hcnt_in = hcnt_ff; rcnt_in = rcnt_ff;
      op_in = op_ff; pos_in = pos_ff; flen_in = flen_ff;
      idx_in = idx_ff; k_in = k_ff; ridx_in = ridx_ff;
      rem_in = rem_ff; cur_in = cur_ff; partial_in = partial_ff;
      pend_in = 1'b0;
      out_v_in = out_v_ff && !rsp_ready;
      out_st_in = out_st_ff; out_iv_in = out_iv_ff;
      out_s_in = out_s_ff; out_l_in = out_l_ff;
      hwe = 1'b0; hwa = '0; hwd = '0; hra = '0;
      rwe = 1'b0; rwa = '0; rwd = '0; rra = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               op_in = op_type'(req_op);
               pos_in = req_position; flen_in = req_fill_length;
               idx_in = '0; k_in = '0; ridx_in = '0; partial_in = 1'b0;
               rem_in = req_fill_length; cur_in = req_position;
               out_iv_in = 1'b0; out_s_in = '0; out_l_in = '0;
               case (op_type'(req_op))
                  OP_CLEAR: begin
                     rcnt_in = '0;
                     out_v_in = 1'b1; out_st_in = ST_OK;
                     if (total_ff == '0) begin
                        hcnt_in = '0;
                     end else begin
                        hwe = 1'b1; hwa = '0;
                        hwd = '{start: '0, length: total_ff};
                        hcnt_in = HoleCntBits'(1);
                        out_iv_in = 1'b1; out_l_in = total_ff;
                     end
                  end
                  OP_FIND_REGION: begin
                     if (req_position >= total_ff) begin
                        out_v_in = 1'b1; out_st_in = ST_BAD;
                     end else begin
                        state_in = S_RSCAN;
                     end
                  end
                  OP_FIND_HOLE: begin
                     if (req_position >= total_ff) begin
                        out_v_in = 1'b1; out_st_in = ST_BAD;
                     end else begin
                        state_in = S_HSCAN;
                     end
                  end
                  default: begin
                     if (req_fill_length == '0) begin
                        out_v_in = 1'b1; out_st_in = ST_BAD;
                     end else begin
                        state_in = S_HSCAN;
                     end
                  end
               endcase
            end
         end
         // Issue read of hole idx, or report not found at the end.
         S_HSCAN: begin
            if (idx_ff >= hcnt_ff) begin
               out_v_in = 1'b1; out_st_in = ST_NOT_FOUND; state_in = S_IDLE;
            end else begin
               hra = idx_ff[HoleIdxBits-1:0]; state_in = S_HCHECK;
            end
         end
         S_HCHECK: begin
            if (op_ff == OP_FILL) begin
               if (hrd.start == pos_ff) begin
                  k_in = '0; state_in = S_RUN;
               end else begin
                  idx_in = idx_ff + 1'b1; state_in = S_HSCAN;
               end
            end else if (hin) begin
               if (hrd.start == pos_ff) begin
                  out_v_in = 1'b1; out_st_in = ST_OK; out_iv_in = 1'b1;
                  out_s_in = pos_ff; out_l_in = hrd.length; state_in = S_IDLE;
               end else if (hcnt_ff >= HoleCntBits'(MaxHoles)) begin
                  out_v_in = 1'b1; out_st_in = ST_FULL; state_in = S_IDLE;
               end else begin
                  // front part stays at i, back part goes to i+1
                  hwe = 1'b1; hwa = idx_ff[HoleIdxBits-1:0];
                  hwd = '{start: hrd.start, length: pos_ff - hrd.start};
                  rem_in = hrd.length - (pos_ff - hrd.start);
                  k_in = hcnt_ff; // shift cursor, moves j-1 to j
                  state_in = S_SPLIT;
               end
            end else begin
               idx_in = idx_ff + 1'b1; state_in = S_HSCAN;
            end
         end
         S_SPLIT: begin
            // k_ff is j; need entry j-1 when j > i+1
            if (k_ff > idx_ff + 1'b1) begin
               if (pend_ff) begin
                  hwe = 1'b1; hwa = k_ff[HoleIdxBits-1:0]; hwd = hrd;
                  k_in = k_ff - 1'b1;
               end else begin
                  hra = HoleIdxBits'(k_ff - 1'b1); pend_in = 1'b1;
               end
            end else begin
               hwe = 1'b1; hwa = HoleIdxBits'(idx_ff + 1'b1);
               hwd = '{start: pos_ff, length: rem_ff};
               hcnt_in = hcnt_ff + 1'b1;
               out_v_in = 1'b1; out_st_in = ST_OK; out_iv_in = 1'b1;
               out_s_in = pos_ff; out_l_in = rem_ff; state_in = S_IDLE;
            end
         end
         S_RSCAN: begin
            if (ridx_ff >= rcnt_ff) begin
               out_v_in = 1'b1; out_st_in = ST_NOT_FOUND; state_in = S_IDLE;
            end else begin
               rra = ridx_ff[RegIdxBits-1:0]; state_in = S_RCHECK;
            end
         end
         S_RCHECK: begin
            if ((rrd.start <= pos_ff) && ((pos_ff - rrd.start) < rrd.length)) begin
               out_v_in = 1'b1; out_st_in = ST_OK; out_iv_in = 1'b1;
               out_s_in = rrd.start; out_l_in = rrd.length; state_in = S_IDLE;
            end else begin
               ridx_in = ridx_ff + 1'b1; state_in = S_RSCAN;
            end
         end
         // Walk the run of contiguous holes from i.
         S_RUN: begin
            if (idx_ff + k_ff >= hcnt_ff) begin
               out_v_in = 1'b1; out_st_in = ST_BAD; state_in = S_IDLE;
            end else begin
               hra = HoleIdxBits'(idx_ff + k_ff); state_in = S_RUNCHK;
            end
         end
         S_RUNCHK: begin
            if (hrd.start != cur_ff) begin
               out_v_in = 1'b1; out_st_in = ST_BAD; state_in = S_IDLE;
            end else if (rem_ff < hrd.length) begin
               partial_in = 1'b1; state_in = S_RINS;
               cur_in = hrd.length; // keep the split hole's length
               ridx_in = rcnt_ff;
            end else begin
               rem_in = rem_ff - hrd.length; cur_in = cur_ff + hrd.length;
               k_in = k_ff + 1'b1;
               if (rem_ff == hrd.length) begin
                  state_in = S_RINS; ridx_in = rcnt_ff;
               end else begin
                  state_in = S_RUN;
               end
            end
            if ((hrd.start == cur_ff) && (rem_ff <= hrd.length)
                && (rcnt_ff >= RegCntBits'(MaxRegions))) begin
               out_v_in = 1'b1; out_st_in = ST_FULL; state_in = S_IDLE;
            end
         end
         // Insert the region: shift entries with start >= pos up by one.
         S_RINS: begin
            if (ridx_ff == '0) begin
               rwe = 1'b1; rwa = '0;
               rwd = '{start: pos_ff, length: flen_ff};
               rcnt_in = rcnt_ff + 1'b1; state_in = S_HDEL;
            end else if (pend_ff) begin
               if (rrd.start < pos_ff) begin
                  rwe = 1'b1; rwa = ridx_ff[RegIdxBits-1:0];
                  rwd = '{start: pos_ff, length: flen_ff};
                  rcnt_in = rcnt_ff + 1'b1; state_in = S_HDEL;
               end else begin
                  rwe = 1'b1; rwa = ridx_ff[RegIdxBits-1:0]; rwd = rrd;
                  ridx_in = ridx_ff - 1'b1;
               end
            end else begin
               rra = RegIdxBits'(ridx_ff - 1'b1); pend_in = 1'b1;
            end
            if (state_in == S_HDEL) begin
               ridx_in = '0;
               if (partial_ff) begin
                  // trimmed hole lives at i+k; with k=0 it is at i
                  hwe = 1'b1; hwa = HoleIdxBits'(idx_ff + k_ff);
                  hwd = '{start: pos_ff + flen_ff, length: cur_ff - rem_ff};
               end
               ridx_in = RegCntBits'(idx_ff); // copy cursor j
            end
         end
         // Move holes j+k down to j.
         S_HDEL: begin
            if (k_ff == '0) begin
               state_in = S_RESULT;
            end else if (HoleCntBits'(ridx_ff) + k_ff >= hcnt_ff) begin
               hcnt_in = hcnt_ff - k_ff; state_in = S_RESULT;
            end else begin
               hra = HoleIdxBits'(HoleCntBits'(ridx_ff) + k_ff);
               state_in = S_HDELW;
            end
         end
         S_HDELW: begin
            hwe = 1'b1; hwa = ridx_ff[HoleIdxBits-1:0]; hwd = hrd;
            ridx_in = ridx_ff + 1'b1; state_in = S_HDEL;
         end
         S_RESULT: begin
            if (hcnt_ff == '0) begin
               out_v_in = 1'b1; out_st_in = ST_OK; state_in = S_IDLE;
            end else begin
               if (idx_ff >= hcnt_ff) begin
                  idx_in = '0; hra = '0;
               end else begin
                  hra = idx_ff[HoleIdxBits-1:0];
               end
               state_in = S_RESW;
            end
         end
         S_RESW: begin
            out_v_in = 1'b1; out_st_in = ST_OK; out_iv_in = 1'b1;
            out_s_in = hrd.start; out_l_in = hrd.length; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hcnt_ff <= '0; rcnt_ff <= '0; total_ff <= '0;
         out_v_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hcnt_ff <= hcnt_in; rcnt_ff <= rcnt_in;
         out_v_ff <= out_v_in; pend_ff <= pend_in;
         if (csr_write_enable) begin
            total_ff <= csr_write_data;
         end
      end
      op_ff <= op_in; pos_ff <= pos_in; flen_ff <= flen_in;
      idx_ff <= idx_in; k_ff <= k_in; ridx_ff <= ridx_in;
      rem_ff <= rem_in; cur_ff <= cur_in; partial_ff <= partial_in;
      out_st_ff <= out_st_in; out_iv_ff <= out_iv_in;
      out_s_ff <= out_s_in; out_l_ff <= out_l_in;
   end
endmodule
`default_nettype wire

/* hw/rtl/srht_checker.sv */
// Port-level checker for the hole tracker, bound to the top level.
`default_nettype none
module srht_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [1:0]        rsp_status,
   input wire logic              rsp_item_valid,
   input wire srht_pkg::pos_type rsp_item_start,
   input wire srht_pkg::pos_type rsp_item_length
);
   import srht_pkg::*;

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while word waits");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item_start)
      && $stable(rsp_status)) else $error("stalled word changed");

   a_item_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_valid |-> rsp_item_start == '0
      && rsp_item_length == '0) else $error("empty item not zero");

   a_item_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_valid |-> rsp_status == ST_OK)
      else $error("item with error status");
endmodule

bind sparse_range_hole_tracker_unit srht_checker u_srht_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
   .rsp_item_valid(rsp_item_valid), .rsp_item_start(rsp_item_start),
   .rsp_item_length(rsp_item_length));
`default_nettype wire

/* verif/sparse_range_hole_tracker_unit_test.sv */
// Self-checking testbench for the sparse range hole tracker: predicts each response word.
`timescale 1ns / 1ps
`default_nettype none
module sparse_range_hole_tracker_unit_test;
   import srht_pkg::*;

   typedef struct packed {
      op_type  op;
      pos_type position;
      pos_type fill_length;
   } req_word_type;

   typedef struct packed {
      status_type status;
      logic       item_valid;
      pos_type    item_start;
      pos_type    item_length;
   } rsp_word_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   logic [1:0] req_op;
   pos_type req_position;
   pos_type req_fill_length;
   logic    rsp_valid;
   logic    rsp_ready;
   logic [1:0] rsp_status;
   logic    rsp_item_valid;
   pos_type rsp_item_start;
   pos_type rsp_item_length;
   logic    csr_write_enable;
   pos_type csr_write_data;

   sparse_range_hole_tracker_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_position(req_position), .req_fill_length(req_fill_length),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_item_valid(rsp_item_valid), .rsp_item_start(rsp_item_start),
      .rsp_item_length(rsp_item_length),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // Shadow copy of the tracker state.
   pos_type buf_size;
   pos_type gap_start [MaxHoles];
   pos_type gap_len [MaxHoles];
   int      gap_count;
   pos_type filled_start [MaxRegions];
   pos_type filled_len [MaxRegions];
   int      filled_count;

   req_word_type pending_words[$];
   rsp_word_type awaited_rsps[$];
   int           error_count;

   function automatic rsp_word_type make_rsp(status_type st, logic v, pos_type s, pos_type l);
      rsp_word_type r;
      r.status = st;
      r.item_valid = v;
      r.item_start = v ? s : '0;
      r.item_length = v ? l : '0;
      return r;
   endfunction

   function automatic bit covers(pos_type p, pos_type s, pos_type l);
      return (s <= p) && ((p - s) < l);
   endfunction

   // Apply one word to the shadow tables and return the response it yields.
   function automatic rsp_word_type track_word(req_word_type w);
      int i, j, k, m;
      logic [32:0] rem_len;
      pos_type cur, front, back;
      bit partial;
      case (w.op)
         OP_CLEAR: begin
            filled_count = 0;
            if (buf_size == 0) begin
               gap_count = 0;
               return make_rsp(ST_OK, 1'b0, '0, '0);
            end
            gap_start[0] = '0;
            gap_len[0] = buf_size;
            gap_count = 1;
            return make_rsp(ST_OK, 1'b1, '0, buf_size);
         end
         OP_FIND_REGION: begin
            if (w.position >= buf_size) return make_rsp(ST_BAD, 1'b0, '0, '0);
            for (i = 0; i < filled_count; i++)
               if (covers(w.position, filled_start[i], filled_len[i]))
                  return make_rsp(ST_OK, 1'b1, filled_start[i], filled_len[i]);
            return make_rsp(ST_NOT_FOUND, 1'b0, '0, '0);
         end
         OP_FIND_HOLE: begin
            if (w.position >= buf_size) return make_rsp(ST_BAD, 1'b0, '0, '0);
            for (i = 0; i < gap_count; i++)
               if (covers(w.position, gap_start[i], gap_len[i])) break;
            if (i >= gap_count) return make_rsp(ST_NOT_FOUND, 1'b0, '0, '0);
            if (gap_start[i] == w.position)
               return make_rsp(ST_OK, 1'b1, w.position, gap_len[i]);
            if (gap_count >= MaxHoles) return make_rsp(ST_FULL, 1'b0, '0, '0);
            front = w.position - gap_start[i];
            back = gap_len[i] - front;
            for (j = gap_count; j > i + 1; j--) begin
               gap_start[j] = gap_start[j-1];
               gap_len[j] = gap_len[j-1];
            end
            gap_len[i] = front;
            gap_start[i+1] = w.position;
            gap_len[i+1] = back;
            gap_count++;
            return make_rsp(ST_OK, 1'b1, w.position, back);
         end
         default: begin
            if (w.fill_length == 0) return make_rsp(ST_BAD, 1'b0, '0, '0);
            for (i = 0; i < gap_count; i++)
               if (gap_start[i] == w.position) break;
            if (i >= gap_count) return make_rsp(ST_NOT_FOUND, 1'b0, '0, '0);
            rem_len = w.fill_length;
            cur = w.position;
            partial = 0;
            k = 0;
            while (rem_len != 0) begin
               j = i + k;
               if (j >= gap_count || gap_start[j] != cur)
                  return make_rsp(ST_BAD, 1'b0, '0, '0);
               if (rem_len < gap_len[j]) begin
                  partial = 1;
                  break;
               end
               rem_len -= gap_len[j];
               cur += gap_len[j];
               k++;
            end
            if (filled_count >= MaxRegions) return make_rsp(ST_FULL, 1'b0, '0, '0);
            for (j = 0; j < filled_count && filled_start[j] < w.position; j++) ;
            for (m = filled_count; m > j; m--) begin
               filled_start[m] = filled_start[m-1];
               filled_len[m] = filled_len[m-1];
            end
            filled_start[j] = w.position;
            filled_len[j] = w.fill_length;
            filled_count++;
            if (partial) begin
               gap_start[i+k] += rem_len[31:0];
               gap_len[i+k] -= rem_len[31:0];
            end
            if (k != 0) begin
               for (j = i; j + k < gap_count; j++) begin
                  gap_start[j] = gap_start[j+k];
                  gap_len[j] = gap_len[j+k];
               end
               gap_count -= k;
            end
            if (gap_count == 0) return make_rsp(ST_OK, 1'b0, '0, '0);
            if (i >= gap_count) i = 0;
            return make_rsp(ST_OK, 1'b1, gap_start[i], gap_len[i]);
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Driver: present queued words with a random pause before each.
   int req_pause;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_op <= '0;
         req_position <= '0;
         req_fill_length <= '0;
         req_pause <= $urandom_range(0, 9);
      end else if (req_valid && !req_ready) begin
         // hold the word until accepted
      end else if (req_pause > 0 || pending_words.size() == 0) begin
         req_valid <= 1'b0;
         if (req_pause > 0) req_pause <= req_pause - 1;
      end else begin
         req_word_type w;
         w = pending_words.pop_front();
         awaited_rsps.push_back(track_word(w));
         req_valid <= 1'b1;
         req_op <= w.op;
         req_position <= w.position;
         req_fill_length <= w.fill_length;
         req_pause <= $urandom_range(0, 9);
      end
   end

   // Monitor: stall responses at random and compare each accepted word.
   int rsp_pause;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_pause <= $urandom_range(0, 9);
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               report_mismatch("unexpected word", 32'(rsp_status), 32'd0);
            end else begin
               rsp_word_type e;
               e = awaited_rsps.pop_front();
               if (rsp_status !== e.status)
                  report_mismatch("status", 32'(rsp_status), 32'(e.status));
               if (rsp_item_valid !== e.item_valid)
                  report_mismatch("item_valid", 32'(rsp_item_valid), 32'(e.item_valid));
               if (rsp_item_start !== e.item_start)
                  report_mismatch("item_start", rsp_item_start, e.item_start);
               if (rsp_item_length !== e.item_length)
                  report_mismatch("item_length", rsp_item_length, e.item_length);
            end
            rsp_pause <= $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else if (rsp_pause > 0) begin
            rsp_pause <= rsp_pause - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_word_type mk(op_type op, pos_type p, pos_type l);
      req_word_type w;
      w.op = op;
      w.position = p;
      w.fill_length = l;
      return w;
   endfunction

   // Wait for the tracker to drain, then let trailing cycles pass.
   task automatic drain;
      while (pending_words.size() != 0 || req_valid || awaited_rsps.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_size(pos_type v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      buf_size = v;
   endtask

   // Random word biased toward hole starts and region interiors of the shadow.
   function automatic req_word_type pick_word(pos_type sz);
      int r;
      pos_type p, l;
      op_type op;
      r = $urandom_range(0, 99);
      op = (r < 3) ? OP_CLEAR : (r < 30) ? OP_FIND_REGION : (r < 55) ? OP_FIND_HOLE : OP_FILL;
      p = (sz == 0) ? $urandom : $urandom_range(0, sz - 1);
      l = $urandom_range(1, 16);
      if ($urandom_range(0, 9) == 0) p = $urandom;
      if ($urandom_range(0, 19) == 0) l = $urandom_range(0, 1) ? 32'd0 : $urandom;
      if (op == OP_FILL && gap_count > 0 && $urandom_range(0, 4) != 0) begin
         r = $urandom_range(0, gap_count - 1);
         p = gap_start[r];
         if ($urandom_range(0, 2) == 0) l = gap_len[r];
         else l = $urandom_range(1, (gap_len[r] > 20) ? 20 : gap_len[r]);
         if ($urandom_range(0, 7) == 0) l = l + $urandom_range(0, 30);
      end else if (op == OP_FIND_REGION && filled_count > 0 && $urandom_range(0, 1)) begin
         r = $urandom_range(0, filled_count - 1);
         p = filled_start[r] + $urandom_range(0, filled_len[r]);
      end
      return mk(op, p, l);
   endfunction

   pos_type size_choices [6] = '{32'd0, 32'd1, 32'd40, 32'd200, 32'd1000, 32'hFFFF_FFFF};

   initial begin
      int ph, n;
      pos_type sz;
      error_count = 0;
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      buf_size = '0;
      gap_count = 0;
      filled_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: a lookup and a fill before any clear, then edges of the fields.
      pending_words.push_back(mk(OP_FIND_REGION, 32'd0, 32'd0));
      pending_words.push_back(mk(OP_FILL, 32'd0, 32'd5));
      drain();
      write_size(32'd100);
      pending_words.push_back(mk(OP_FIND_HOLE, 32'd5, 32'd0));
      pending_words.push_back(mk(OP_CLEAR, 32'd0, 32'd0));
      pending_words.push_back(mk(OP_FIND_HOLE, 32'd100, 32'd0));
      pending_words.push_back(mk(OP_FIND_REGION, 32'hFFFF_FFFF, 32'd0));
      pending_words.push_back(mk(OP_FIND_HOLE, 32'd0, 32'd0));
      pending_words.push_back(mk(OP_FIND_HOLE, 32'd50, 32'd0));
      pending_words.push_back(mk(OP_FILL, 32'd0, 32'd0));
      pending_words.push_back(mk(OP_FILL, 32'd7, 32'd3));
      pending_words.push_back(mk(OP_FILL, 32'd0, 32'd51));
      pending_words.push_back(mk(OP_FILL, 32'd0, 32'd20));
      pending_words.push_back(mk(OP_FIND_REGION, 32'd19, 32'd0));
      pending_words.push_back(mk(OP_FIND_REGION, 32'd20, 32'd0));
      pending_words.push_back(mk(OP_FILL, 32'd20, 32'd80));
      pending_words.push_back(mk(OP_FILL, 32'd50, 32'hFFFF_FFFF));
      pending_words.push_back(mk(OP_FIND_HOLE, 32'd60, 32'd0));
      pending_words.push_back(mk(OP_CLEAR, 32'd0, 32'd0));
      drain();
      // Fill the hole table with one-byte splits to reach table full.
      write_size(32'd80);
      pending_words.push_back(mk(OP_CLEAR, 32'd0, 32'd0));
      for (n = 1; n < 66; n++)
         pending_words.push_back(mk(OP_FIND_HOLE, pos_type'(n), 32'd0));
      for (n = 0; n < 66; n++)
         pending_words.push_back(mk(OP_FILL, pos_type'(n), 32'd1));
      drain();

      // Random phases over several buffer sizes.
      for (ph = 0; ph < 8; ph++) begin
         sz = (ph < 6) ? size_choices[ph] : $urandom_range(2, 300);
         write_size(sz);
         pending_words.push_back(mk(OP_CLEAR, 32'd0, 32'd0));
         for (n = 0; n < 170; n++) begin
            while (pending_words.size() > 2) @(posedge clock);
            pending_words.push_back(pick_word(sz));
         end
         drain();
      end
      if (error_count == 0) $display("sparse_range_hole_tracker_unit verification clean");
      else $display("sparse_range_hole_tracker_unit verification failed");
      $finish;
   end

   initial begin
      #40ms;
      $display("sparse_range_hole_tracker_unit verification failed");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
hw/rtl/srht_pkg.sv
hw/rtl/srht_ram.sv
hw/rtl/sparse_range_hole_tracker_unit.sv
hw/rtl/srht_checker.sv
verif/sparse_range_hole_tracker_unit_test.sv
